// ----- design/wfeg_pkg.sv -----
// Shared types and constants for the wheel frame event generator.
package wfeg_pkg;

  localparam int AXIS_BITS  = 10;
  localparam int NUM_AXES   = 3;
  localparam int AXES_BITS  = NUM_AXES * AXIS_BITS;
  localparam int BTN_BITS   = 32;
  localparam int KIND_COUNT = 5;
  localparam int FRAME_BYTES = 6;
  localparam int IN_DATA_BITS  = 8 * FRAME_BYTES;
  // button word plus three axes, padded to whole bytes
  localparam int OUT_DATA_BITS = 64;
  localparam int KIND_BITS  = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 10;

  typedef logic [AXIS_BITS-1:0]  axis_t;
  typedef logic [BTN_BITS-1:0]   btn_t;
  typedef logic [KIND_COUNT-1:0] kind_mask_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PRESSED  = 3'd0,
    KIND_RELEASED = 3'd1,
    KIND_UPDATE   = 3'd2,
    KIND_MOVED    = 3'd3,
    KIND_ARRIVED  = 3'd4
  } kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_EVENT_MASK    = 2'd0,
    CFG_RECOVER_LOST  = 2'd1,
    CFG_MOVE_DEADBAND = 2'd2
  } cfg_index_t;

  // Bits 19..18 of the button word are always reported on edge records.
  localparam btn_t STICKY_BTN_MASK = 32'h000C_0000;

  localparam kind_mask_t EVENT_MASK_RESET    = 5'd31;
  localparam axis_t      MOVE_DEADBAND_RESET = 10'd1;

endpackage

// ----- design/wheel_frame_event_generator_unit.sv -----
// Wheel frame event generator: unpacks port frames and emits masked event records.
//
// Usage:
//   s_axis_* takes one six-byte port frame per beat. m_axis_* gives event
//   records: tuser carries the event kind, tdata the button word and the
//   three axis positions, tlast marks the final record of a frame. The cfg_*
//   channel writes event_mask (index 0), recover_lost (1) and move_deadband
//   (2); it is always ready and leaves the user to write it only while idle.
//
// Timing and flow:
//   A frame is decoded and compared against the held button and axis state
//   in the cycle it is accepted; its records are queued in a frame register
//   as a pending-kind mask. One record per cycle, while the receiver is
//   ready, moves from there into the output register, lowest kind first,
//   so a record is seen only after passing both registers. A frame yields
//   up to five records; the next frame is taken in the same cycle the last
//   record of the current one moves to the output register. A frame with no
//   enabled event updates the state and emits nothing, one frame per cycle.
//
// Reset: clears the pending mask, the output valid, the button and reported
// axis state, and loads the register defaults (mask 31, recovery off,
// deadband 1).
// Stall: while the receiver holds tready low the output register holds its
// record, the frame register keeps its pending kinds and s_axis_tready drops
// once no record can advance.
module wheel_frame_event_generator_unit (
  input  logic clk,
  input  logic rst,
  // frame input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] port_byte_a, [15:8] port_byte_b, [23:16] port_byte_c,
  // [31:24] port_byte_d, [39:32] port_byte_e, [47:40] port_byte_f
  input  logic [wfeg_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // record output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] button_word, [41:32] pos_x, [51:42] pos_y, [61:52] pos_z, [63:62] zero
  output logic [wfeg_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // [2:0] event_kind
  output logic [wfeg_pkg::KIND_BITS-1:0]      m_axis_tuser,
  // last_record
  output logic                                m_axis_tlast,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wfeg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wfeg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers
  wfeg_pkg::kind_mask_t event_mask;
  logic                 recover_lost;
  wfeg_pkg::axis_t      move_deadband;

  // Held state across frames
  wfeg_pkg::btn_t                   buttons_now;
  logic [wfeg_pkg::AXES_BITS-1:0]   axes_reported;

  // Frame register: pending kinds and what the records carry
  wfeg_pkg::kind_mask_t             pend;
  wfeg_pkg::btn_t                   frame_btn;
  wfeg_pkg::btn_t                   frame_press;
  wfeg_pkg::btn_t                   frame_release;
  logic [wfeg_pkg::AXES_BITS-1:0]   frame_axes;

  // Output register
  logic                             out_valid;
  wfeg_pkg::kind_t                  out_kind;
  wfeg_pkg::btn_t                   out_word;
  logic [wfeg_pkg::AXES_BITS-1:0]   out_axes;
  logic                             out_last;

  // Decode of the incoming frame
  wfeg_pkg::axis_t                  in_x, in_y, in_z;
  wfeg_pkg::btn_t                   in_btn, in_down, in_up;
  logic [wfeg_pkg::AXES_BITS-1:0]   in_axes;
  logic                             in_moved;
  wfeg_pkg::kind_mask_t             in_events, in_pend;

  // Record selection
  wfeg_pkg::kind_mask_t             pick, pend_rest;
  wfeg_pkg::kind_t                  pick_kind;
  wfeg_pkg::btn_t                   pick_word;
  logic                             out_load;
  logic                             s_accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_x = {s_axis_tdata[7:0], s_axis_tdata[15:14]};
    in_y = {s_axis_tdata[13:8], s_axis_tdata[23:20]};
    in_z = {s_axis_tdata[19:16], s_axis_tdata[31:26]};
    in_btn = {s_axis_tdata[39:32], s_axis_tdata[47:44], s_axis_tdata[25:24], 18'd0};
    in_down = in_btn & ~buttons_now;
    in_up   = buttons_now & ~in_btn;
    in_axes = {in_z, in_y, in_x};
  end

  // Moved when any axis strays more than the deadband from the last report.
  always_comb begin
    wfeg_pkg::axis_t a_old;
    wfeg_pkg::axis_t a_new;
    wfeg_pkg::axis_t diff;
    in_moved = 1'b0;
    for (int k = 0; k < wfeg_pkg::NUM_AXES; k++) begin
      a_old = axes_reported[k*wfeg_pkg::AXIS_BITS +: wfeg_pkg::AXIS_BITS];
      a_new = in_axes[k*wfeg_pkg::AXIS_BITS +: wfeg_pkg::AXIS_BITS];
      diff = (a_old > a_new) ? (a_old - a_new) : (a_new - a_old);
      if (diff > move_deadband) begin
        in_moved = 1'b1;
      end
    end
  end

  always_comb begin
    in_events = '0;
    in_events[wfeg_pkg::KIND_PRESSED]  = |in_down;
    in_events[wfeg_pkg::KIND_RELEASED] = |in_up;
    in_events[wfeg_pkg::KIND_UPDATE]   = |(in_down | in_up);
    in_events[wfeg_pkg::KIND_MOVED]    = in_moved;
    in_events[wfeg_pkg::KIND_ARRIVED]  = 1'b1;
    in_pend = in_events & event_mask;
    // recovery mode forces the update record regardless of the mask
    in_pend[wfeg_pkg::KIND_UPDATE] = in_pend[wfeg_pkg::KIND_UPDATE] | recover_lost;
  end

  // Lowest pending kind goes first.
  always_comb begin
    pick = pend & (~pend + wfeg_pkg::kind_mask_t'(1));
    pend_rest = pend & ~pick;
    pick_kind = wfeg_pkg::KIND_ARRIVED;
    if (pick[wfeg_pkg::KIND_PRESSED]) begin
      pick_kind = wfeg_pkg::KIND_PRESSED;
    end else if (pick[wfeg_pkg::KIND_RELEASED]) begin
      pick_kind = wfeg_pkg::KIND_RELEASED;
    end else if (pick[wfeg_pkg::KIND_UPDATE]) begin
      pick_kind = wfeg_pkg::KIND_UPDATE;
    end else if (pick[wfeg_pkg::KIND_MOVED]) begin
      pick_kind = wfeg_pkg::KIND_MOVED;
    end
    unique case (pick_kind)
      wfeg_pkg::KIND_PRESSED:  pick_word = frame_press;
      wfeg_pkg::KIND_RELEASED: pick_word = frame_release;
      default:                 pick_word = frame_btn;
    endcase
  end

  assign out_load      = (|pend) && (!out_valid || m_axis_tready);
  assign s_axis_tready = (pend == '0) || (out_load && (pend_rest == '0));
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      event_mask    <= wfeg_pkg::EVENT_MASK_RESET;
      recover_lost  <= 1'b0;
      move_deadband <= wfeg_pkg::MOVE_DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wfeg_pkg::CFG_EVENT_MASK:
          event_mask <= cfg_data[wfeg_pkg::KIND_COUNT-1:0];
        wfeg_pkg::CFG_RECOVER_LOST:
          recover_lost <= cfg_data[0];
        wfeg_pkg::CFG_MOVE_DEADBAND:
          move_deadband <= cfg_data[wfeg_pkg::AXIS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Held state and pending mask; a new frame is only taken once the last
  // pending record leaves, so it simply replaces the mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      buttons_now   <= '0;
      axes_reported <= '0;
      pend          <= '0;
    end else begin
      if (s_accept) begin
        buttons_now <= in_btn;
        if (in_moved) begin
          axes_reported <= in_axes;
        end
        pend <= in_pend;
      end else if (out_load) begin
        pend <= pend_rest;
      end
    end
  end

  // Frame payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      frame_btn     <= in_btn;
      frame_press   <= in_down | (in_btn & wfeg_pkg::STICKY_BTN_MASK);
      frame_release <= in_up | (in_btn & wfeg_pkg::STICKY_BTN_MASK);
      frame_axes    <= in_axes;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= pick_kind;
      out_word <= pick_word;
      out_axes <= frame_axes;
      out_last <= (pend_rest == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_axes, out_word};

  // A frame with more than one record left must hold off the next frame.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    ($countones(pend) > 1) |-> !s_axis_tready)
    else $error("frame accepted while several records still pending");

  // Recovery mode always queues the update record.
  a_recover_update: assert property (@(posedge clk) disable iff (rst)
    (s_accept && recover_lost) |=> pend[wfeg_pkg::KIND_UPDATE])
    else $error("update record missing in recovery mode");

  // Moving the final record out empties the frame register.
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_load && (pend_rest == '0) && !s_accept) |=> (pend == '0))
    else $error("pending kinds left after final record");

endmodule
